FILE: design/hcbd_pkg.sv
// hcbd_pkg: shared types and constants for the chunked body decoder
// transaction payload structs, result kind and error codes
// no dependencies
package hcbd_pkg;

  localparam logic [7:0] ByteCr = 8'h0D;
  localparam logic [7:0] ByteLf = 8'h0A;

  // a size line LF only counts from this byte of the line on
  localparam int unsigned MinLfCount = 3;

  localparam int unsigned SizeW = 12;
  localparam logic [SizeW-1:0] SizeMax = {SizeW{1'b1}};

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_DATA = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_LINE_LEN = 2'd1,
    ERR_TAIL     = 2'd2,
    ERR_CAPACITY = 2'd3
  } error_e;

  typedef enum logic {
    ACT_BYTE    = 1'b0,
    ACT_RESTART = 1'b1
  } action_e;

  typedef struct packed {
    logic       action;
    logic [7:0] body_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_offset;
    logic [1:0]  error_code;
    logic [15:0] total_length;
  } out_item_t;

endpackage

FILE: design/http_chunked_body_decoder.sv
// Chunked HTTP/1.1 body decoder: turns a chunked body, one byte per transaction,
// into payload bytes with their offsets, plus finish and error reports.
// Usage:
//   in channel  (in_valid_i/in_ready_o, in_data_i): one body byte or a restart
//     per transaction; a restart returns the parser to the start of a body.
//   out channel (out_valid_o/out_ready_i, out_data_o): exactly one result per
//     input transaction, in order; kind tells payload, finish, error or nothing.
//   cfg channel (cfg_valid_i/cfg_ready_o, cfg_data_i): writes buffer capacity;
//     always ready, write it only while the decoder is idle.
// The result is registered and shows in the cycle after its input transaction.
// One byte is taken every cycle while results are taken: the parser state
// updates in a single pass of compares and adds into the result register.
// The result register frees up in the same cycle it is taken, so a stalled
// receiver stalls the input only while a result is waiting.
// Reset clears the parser to the size line state, empties the result
// register and sets buffer capacity to 4096.
// After finish or an error the parser answers kind none until a restart.
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int unsigned SIZE_LINE_BUFFER = 6
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned LcW = $clog2(SIZE_LINE_BUFFER);
  localparam logic [LcW-1:0] LineLimit = LcW'(SIZE_LINE_BUFFER - 1);
  localparam logic [LcW-1:0] LfMin = LcW'(MinLfCount);

  typedef enum logic [2:0] {
    PH_LINE  = 3'd0,
    PH_DATA  = 3'd1,
    PH_TAIL  = 3'd2,
    PH_FINAL = 3'd3,
    PH_IDLE  = 3'd4
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [LcW-1:0]   line_cnt_q, line_cnt_d;
  logic [SizeW-1:0] size_q, size_d;
  logic             hex_stop_q, hex_stop_d;
  logic             last_cr_q, last_cr_d;
  logic [SizeW-1:0] left_q, left_d;
  logic [15:0]      total_q, total_d;
  logic [15:0]      capacity_q;

  logic      out_valid_q;
  out_item_t out_q, res;

  logic in_fire;

  logic [LcW-1:0]   line_cnt_inc;
  logic             is_hex;
  logic [3:0]       hex_val;
  logic [SizeW+3:0] size_acc;
  logic [17:0]      need;
  logic [7:0]       b;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign b = in_data_i.body_byte;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_val = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_val = 4'(b - 8'h57);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign line_cnt_inc = line_cnt_q + LcW'(1);
  assign size_acc     = {size_q, 4'd0} + {{SizeW{1'b0}}, hex_val};
  // chunk fits when size + total + 1 <= capacity
  assign need = {6'd0, size_q} + {2'd0, total_q} + 18'd1;

  always_comb begin
    phase_d    = phase_q;
    line_cnt_d = line_cnt_q;
    size_d     = size_q;
    hex_stop_d = hex_stop_q;
    last_cr_d  = last_cr_q;
    left_d     = left_q;
    total_d    = total_q;

    res                = '0;
    res.kind           = KIND_NONE;
    res.error_code     = ERR_NONE;

    if (in_data_i.action == ACT_RESTART) begin
      phase_d    = PH_LINE;
      line_cnt_d = '0;
      size_d     = '0;
      hex_stop_d = 1'b0;
      last_cr_d  = 1'b0;
      left_d     = '0;
      total_d    = '0;
    end else begin
      case (phase_q)
        PH_LINE: begin
          line_cnt_d = line_cnt_inc;
          if (line_cnt_inc >= LfMin && last_cr_q && b == ByteLf) begin
            line_cnt_d = '0;
            size_d     = '0;
            hex_stop_d = 1'b0;
            last_cr_d  = 1'b0;
            if (size_q == '0) begin
              phase_d = PH_FINAL;
            end else if (need > {2'd0, capacity_q}) begin
              res.kind       = KIND_ERR;
              res.error_code = ERR_CAPACITY;
              phase_d        = PH_IDLE;
            end else begin
              left_d  = size_q;
              phase_d = PH_DATA;
            end
          end else begin
            if (!hex_stop_q) begin
              if (!is_hex) begin
                hex_stop_d = 1'b1;
              end else if (size_acc[SizeW+3:SizeW] != '0) begin
                size_d = SizeMax;
              end else begin
                size_d = size_acc[SizeW-1:0];
              end
            end
            last_cr_d = (b == ByteCr);
            if (line_cnt_inc >= LineLimit) begin
              res.kind       = KIND_ERR;
              res.error_code = ERR_LINE_LEN;
              phase_d        = PH_IDLE;
              line_cnt_d     = '0;
              size_d         = '0;
              hex_stop_d     = 1'b0;
              last_cr_d      = 1'b0;
            end
          end
        end
        PH_DATA: begin
          res.kind           = KIND_DATA;
          res.payload_byte   = b;
          res.payload_offset = total_q;
          total_d            = total_q + 16'd1;
          if (left_q <= SizeW'(1)) begin
            left_d     = '0;
            phase_d    = PH_TAIL;
            line_cnt_d = '0;
            last_cr_d  = 1'b0;
          end else begin
            left_d = left_q - SizeW'(1);
          end
        end
        PH_TAIL, PH_FINAL: begin
          if (line_cnt_q == '0) begin
            last_cr_d  = (b == ByteCr);
            line_cnt_d = LcW'(1);
          end else begin
            line_cnt_d = '0;
            size_d     = '0;
            hex_stop_d = 1'b0;
            last_cr_d  = 1'b0;
            if (!(last_cr_q && b == ByteLf)) begin
              res.kind       = KIND_ERR;
              res.error_code = ERR_TAIL;
              phase_d        = PH_IDLE;
            end else if (phase_q == PH_FINAL) begin
              res.kind = KIND_DONE;
              phase_d  = PH_IDLE;
            end else begin
              phase_d = PH_LINE;
            end
          end
        end
        default: begin
          // idle and unused codes: nothing to report
        end
      endcase
    end
    res.total_length = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LINE;
      line_cnt_q  <= '0;
      size_q      <= '0;
      hex_stop_q  <= 1'b0;
      last_cr_q   <= 1'b0;
      left_q      <= '0;
      total_q     <= '0;
      capacity_q  <= 16'd4096;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_data_i;
      end
      if (in_fire) begin
        phase_q     <= phase_d;
        line_cnt_q  <= line_cnt_d;
        size_q      <= size_d;
        hex_stop_q  <= hex_stop_d;
        last_cr_q   <= last_cr_d;
        left_q      <= left_d;
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

  // every accepted transaction leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("result missing after input transaction");

  // a data chunk always has bytes left while in the data phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> left_q != '0)
    else $error("data phase with no bytes left");

  // an error or finish result always parks the parser
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (res.kind == KIND_ERR || res.kind == KIND_DONE) |=> phase_q == PH_IDLE)
    else $error("parser not idle after error or finish");

  // error code only accompanies an error result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_ERR |-> out_data_o.error_code == ERR_NONE)
    else $error("error code set on a non-error result");

endmodule
